@@ design/dvrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned PortCountDef  = 8;

  localparam int unsigned AddrW = 32;
  localparam int unsigned MacW  = 48;
  localparam int unsigned PortW = 3;
  localparam int unsigned DistW = 8;
  localparam int unsigned LifeW = 16;
  localparam int unsigned FuncW = 3;
  localparam int unsigned CodeW = 2;

  localparam logic [LifeW-1:0] LifeReset = 16'd30;
  localparam logic [DistW-1:0] DistMax   = 8'hff;

  // one table entry: valid is held in flip-flops, the rest lives in RAM
  localparam int unsigned EntryW = AddrW + MacW + PortW + DistW + LifeW + 1;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_LOOKUP  = 3'd1,
    FUNC_STATIC  = 3'd2,
    FUNC_LEARN   = 3'd3,
    FUNC_ADVERT  = 3'd4,
    FUNC_INVALID = 3'd7
  } func_t;

  typedef enum logic [CodeW-1:0] {
    CODE_DONE  = 2'd0,
    CODE_SAME  = 2'd1,
    CODE_FULL  = 2'd2,
    CODE_SPLIT = 2'd3
  } code_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [MacW-1:0]  mac;
    logic [PortW-1:0] port;
    logic [DistW-1:0] metric;
    logic [LifeW-1:0] life;
    logic             perm;
  } entry_t;

endpackage

@@ design/dvrt_ram.sv @@
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dvrt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/distance_vector_route_table_top.sv @@
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Exact-match route table with distance-vector learning, one slot per step.
// ----------------------------------------------------------------------------
// every command scans all slots: one read and one optional write-back per slot
//   through a single RAM port
// throughput: one command at a time, busy stays high until the result strobe
// reset: valid bits clear at once, route_lifetime returns to 30; the receiver
//   cannot stall, out_valid is a single-cycle strobe
module distance_vector_route_table_top
  import dvrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned PORT_COUNT  = PortCountDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dvrt_pkg::LifeW-1:0]    cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [dvrt_pkg::FuncW-1:0]    in_func,
  input  logic [dvrt_pkg::AddrW-1:0]    in_entry_addr,
  input  logic [dvrt_pkg::MacW-1:0]     in_next_hop_mac,
  input  logic [dvrt_pkg::MacW-1:0]     in_advertised_mac,
  input  logic [dvrt_pkg::MacW-1:0]     in_own_port_mac,
  input  logic [dvrt_pkg::PortW-1:0]    in_port,
  input  logic [dvrt_pkg::DistW-1:0]    in_distance,
  input  logic                          in_permanent,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [dvrt_pkg::PortW-1:0]    out_out_port,
  output logic [dvrt_pkg::MacW-1:0]     out_out_mac,
  output logic [dvrt_pkg::DistW-1:0]    out_out_distance,
  output logic [dvrt_pkg::CodeW-1:0]    out_result_code
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(TABLE_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [LifeW-1:0] life_cfg_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;

  // latched command
  logic [FuncW-1:0] func_r;
  logic [AddrW-1:0] addr_r;
  logic [MacW-1:0]  mac_r;
  logic [PortW-1:0] port_r;
  logic [DistW-1:0] dist_r;
  logic             perm_r;
  logic             split_r;

  // scan results
  logic             found_r, found_nxt;
  logic [IdxW-1:0]  match_r, match_nxt;
  logic [DistW-1:0] match_dist_r;
  logic             free_ok_r, free_ok_nxt;
  logic [IdxW-1:0]  free_r, free_nxt;
  logic             hit_r, hit_nxt;
  entry_t           hit_e_r, hit_e_nxt;
  logic [CodeW-1:0] code_r, code_nxt;

  logic             ram_we;
  logic [IdxW-1:0]  ram_addr;
  entry_t           ram_wdata, ram_rdata;
  logic [EntryW-1:0] ram_rbits;

  dvrt_ram #(.Width(EntryW), .Depth(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rbits)
  );
  assign ram_rdata = entry_t'(ram_rbits);

  logic [IdxW-1:0] cur;
  logic            in_port_ok;
  logic [DistW-1:0] new_dist;
  entry_t          new_e;
  logic            scan_slot_valid;

  assign cur = idx_r[IdxW-1:0];
  assign in_port_ok = (CntW + 8)'(in_port) < (CntW + 8)'(PORT_COUNT);
  assign new_dist = (dist_r == DistMax) ? DistMax : dist_r + 8'd1;
  assign scan_slot_valid = valid_r[cur];
  assign busy = (state_r != ST_IDLE);

  always_comb begin
    new_e.addr = addr_r;
    new_e.mac  = mac_r;
    new_e.port = port_r;
    new_e.life = life_cfg_r;
    unique case (func_r)
      FUNC_STATIC: begin
        new_e.metric = dist_r;
        new_e.perm   = perm_r;
      end
      FUNC_LEARN: begin
        new_e.metric = 8'd1;
        new_e.perm   = 1'b0;
      end
      default: begin
        new_e.metric = new_dist;
        new_e.perm   = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    match_nxt   = match_r;
    free_ok_nxt = free_ok_r;
    free_nxt    = free_r;
    hit_nxt     = hit_r;
    hit_e_nxt   = hit_e_r;
    code_nxt    = code_r;
    ram_we      = 1'b0;
    ram_addr    = cur;
    ram_wdata   = ram_rdata;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt     = '0;
        found_nxt   = 1'b0;
        free_ok_nxt = 1'b0;
        hit_nxt     = 1'b0;
        if (start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (idx_r == LastCnt) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_READ;
        idx_nxt   = idx_r + CntW'(1);
        if (func_r == FUNC_TICK) begin
          if (scan_slot_valid && !ram_rdata.perm) begin
            ram_we = 1'b1;
            if (ram_rdata.life <= 16'd1) begin
              valid_nxt[cur] = 1'b0;
              ram_wdata.life = '0;
            end else begin
              ram_wdata.life = ram_rdata.life - 16'd1;
            end
          end
        end else begin
          if (scan_slot_valid && ram_rdata.addr == addr_r && !found_r) begin
            found_nxt = 1'b1;
            match_nxt = cur;
          end
          if (!scan_slot_valid && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt    = cur;
          end
          if (scan_slot_valid && ram_rdata.addr == addr_r && !hit_r &&
              (ram_rdata.perm || ram_rdata.life != '0)) begin
            hit_nxt   = 1'b1;
            hit_e_nxt = ram_rdata;
          end
        end
      end
      ST_WRITE: begin
        // distance of the first address match was captured during the scan
        state_nxt = ST_DONE;
        ram_wdata = new_e;
        code_nxt  = CODE_SAME;
        priority if (split_r) begin
          code_nxt = CODE_SPLIT;
        end else if (func_r == FUNC_TICK || func_r == FUNC_LOOKUP) begin
          code_nxt = CODE_DONE;
        end else if (func_r == FUNC_STATIC ||
                     ((func_r == FUNC_LEARN || func_r == FUNC_ADVERT) && !found_r)) begin
          if (free_ok_r) begin
            ram_we   = 1'b1;
            ram_addr = free_r;
            valid_nxt[free_r] = 1'b1;
            code_nxt = CODE_DONE;
          end else begin
            code_nxt = CODE_FULL;
          end
        end else if (func_r == FUNC_LEARN) begin
          ram_we   = 1'b1;
          ram_addr = match_r;
          code_nxt = CODE_DONE;
        end else if (func_r == FUNC_ADVERT) begin
          if (match_dist_r > new_dist) begin
            ram_we   = 1'b1;
            ram_addr = match_r;
            code_nxt = CODE_DONE;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= '0;
      life_cfg_r <= LifeReset;
      out_valid  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      out_valid <= (state_r == ST_DONE);
      if (cfg_we) begin
        life_cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    found_r   <= found_nxt;
    match_r   <= match_nxt;
    free_ok_r <= free_ok_nxt;
    free_r    <= free_nxt;
    hit_r     <= hit_nxt;
    hit_e_r   <= hit_e_nxt;
    code_r    <= code_nxt;
    // distance of the first valid address match, live or not
    if (state_r == ST_EVAL && func_r == FUNC_ADVERT && scan_slot_valid &&
        ram_rdata.addr == addr_r && !found_r) begin
      match_dist_r <= ram_rdata.metric;
    end
    if (state_r == ST_IDLE && start) begin
      func_r  <= in_func;
      addr_r  <= in_entry_addr;
      mac_r   <= in_next_hop_mac;
      port_r  <= in_port;
      dist_r  <= in_distance;
      perm_r  <= in_permanent;
      split_r <= (in_func == FUNC_ADVERT) && in_port_ok &&
                 (in_advertised_mac == in_own_port_mac);
      if (!in_port_ok && (in_func == FUNC_STATIC || in_func == FUNC_LEARN ||
                          in_func == FUNC_ADVERT)) begin
        func_r <= FUNC_INVALID;
      end
    end
  end

  always_comb begin
    out_hit          = 1'b0;
    out_out_port     = '0;
    out_out_mac      = '0;
    out_out_distance = '0;
    out_result_code  = code_r;
    if (func_r == FUNC_LOOKUP && hit_r) begin
      out_hit          = 1'b1;
      out_out_port     = hit_e_r.port;
      out_out_mac      = hit_e_r.mac;
      out_out_distance = hit_e_r.metric;
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the distance-vector route table: a table of directed commands, then
// random command streams over several route lifetimes, each result compared
// field by field with a fixed expectation or the behavioral table model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import dvrt_pkg::*;

  localparam int unsigned Depth       = TableDepthDef;
  localparam int unsigned Latency     = 2 * Depth + 3;
  localparam longint      CycleLimit  = 1000000;
  localparam int unsigned PhaseItems  = 160;
  localparam logic [FuncW-1:0] FuncBadLo = 3'd5;
  localparam logic [FuncW-1:0] FuncBadHi = 3'd7;
  localparam logic [MacW-1:0]  MacOnes   = '1;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [AddrW-1:0] addr;
    logic [MacW-1:0]  nh_mac;
    logic [MacW-1:0]  adv_mac;
    logic [MacW-1:0]  own_mac;
    logic [PortW-1:0] port;
    logic [DistW-1:0] metric;
    logic             perm;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [PortW-1:0] port;
    logic [MacW-1:0]  mac;
    logic [DistW-1:0] metric;
    logic [CodeW-1:0] code;
  } outcome_t;

  typedef struct packed {
    cmd_t     c;
    logic     typed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [LifeW-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [FuncW-1:0] in_func = '0;
  logic [AddrW-1:0] in_entry_addr = '0;
  logic [MacW-1:0]  in_next_hop_mac = '0;
  logic [MacW-1:0]  in_advertised_mac = '0;
  logic [MacW-1:0]  in_own_port_mac = '0;
  logic [PortW-1:0] in_port = '0;
  logic [DistW-1:0] in_distance = '0;
  logic             in_permanent = 1'b0;
  logic             out_valid;
  logic             out_hit;
  logic [PortW-1:0] out_out_port;
  logic [MacW-1:0]  out_out_mac;
  logic [DistW-1:0] out_out_distance;
  logic [CodeW-1:0] out_result_code;

  distance_vector_route_table_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .in_func(in_func), .in_entry_addr(in_entry_addr),
    .in_next_hop_mac(in_next_hop_mac), .in_advertised_mac(in_advertised_mac),
    .in_own_port_mac(in_own_port_mac), .in_port(in_port), .in_distance(in_distance),
    .in_permanent(in_permanent), .out_valid(out_valid), .out_hit(out_hit),
    .out_out_port(out_out_port), .out_out_mac(out_out_mac),
    .out_out_distance(out_out_distance), .out_result_code(out_result_code)
  );

  always #4 clk = ~clk;

  // bench copy of the route table
  logic [LifeW-1:0] route_lifetime;
  logic             route_valid [Depth];
  logic [AddrW-1:0] route_addr [Depth];
  logic [MacW-1:0]  route_mac [Depth];
  logic [PortW-1:0] route_port [Depth];
  logic [DistW-1:0] route_dist [Depth];
  logic [LifeW-1:0] route_life [Depth];
  logic             route_perm [Depth];

  outcome_t  pending_results[$];
  row_t      directed_rows[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        code_count [4] = '{0, 0, 0, 0};
  int        hits_seen = 0;
  longint    cycles = 0;
  bit        idle_on = 1'b1;
  logic [AddrW-1:0] addr_pool [12];
  logic [MacW-1:0]  mac_pool [4];

  function automatic int find_match(logic [AddrW-1:0] a);
    for (int i = 0; i < Depth; i++)
      if (route_valid[i] && route_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic void write_route(int i, cmd_t c, logic [DistW-1:0] d, logic p);
    route_valid[i] = 1'b1;
    route_addr[i]  = c.addr;
    route_mac[i]   = c.nh_mac;
    route_port[i]  = c.port;
    route_dist[i]  = d;
    route_life[i]  = route_lifetime;
    route_perm[i]  = p;
  endfunction

  function automatic logic [CodeW-1:0] insert_route(cmd_t c, logic [DistW-1:0] d,
                                                    logic p);
    for (int i = 0; i < Depth; i++)
      if (!route_valid[i]) begin
        write_route(i, c, d, p);
        return CODE_DONE;
      end
    return CODE_FULL;
  endfunction

  function automatic outcome_t route_apply(cmd_t c);
    outcome_t r;
    logic [FuncW-1:0] fn;
    logic [DistW-1:0] nd;
    int m;
    r = '0;
    r.code = CODE_SAME;
    fn = c.func;
    if ((fn == FUNC_STATIC || fn == FUNC_LEARN || fn == FUNC_ADVERT)
        && c.port >= PortCountDef)
      fn = FuncBadHi;
    if (fn == FUNC_TICK) begin
      for (int i = 0; i < Depth; i++)
        if (route_valid[i] && !route_perm[i]) begin
          if (route_life[i] <= 1) begin
            route_valid[i] = 1'b0;
            route_life[i] = '0;
          end else begin
            route_life[i] = route_life[i] - 1'b1;
          end
        end
      r.code = CODE_DONE;
    end else if (fn == FUNC_LOOKUP) begin
      for (int i = 0; i < Depth; i++)
        if (route_valid[i] && (route_perm[i] || route_life[i] != 0)
            && route_addr[i] == c.addr) begin
          r.hit = 1'b1;
          r.port = route_port[i];
          r.mac = route_mac[i];
          r.metric = route_dist[i];
          break;
        end
      r.code = CODE_DONE;
    end else if (fn == FUNC_STATIC) begin
      r.code = insert_route(c, c.metric, c.perm);
    end else if (fn == FUNC_LEARN) begin
      m = find_match(c.addr);
      if (m >= 0) begin
        write_route(m, c, 8'd1, 1'b0);
        r.code = CODE_DONE;
      end else begin
        r.code = insert_route(c, 8'd1, 1'b0);
      end
    end else if (fn == FUNC_ADVERT) begin
      if (c.adv_mac == c.own_mac) begin
        r.code = CODE_SPLIT;
      end else begin
        nd = (c.metric == DistMax) ? DistMax : c.metric + 8'd1;
        m = find_match(c.addr);
        if (m >= 0) begin
          if (route_dist[m] > nd) begin
            write_route(m, c, nd, 1'b0);
            r.code = CODE_DONE;
          end
        end else begin
          r.code = insert_route(c, nd, 1'b0);
        end
      end
    end
    return r;
  endfunction

  function automatic cmd_t mk(logic [FuncW-1:0] f, logic [AddrW-1:0] a,
                              logic [MacW-1:0] nh, logic [MacW-1:0] adv,
                              logic [MacW-1:0] own, logic [PortW-1:0] p,
                              logic [DistW-1:0] d, logic pm);
    cmd_t c;
    c = '{f, a, nh, adv, own, p, d, pm};
    return c;
  endfunction

  function automatic outcome_t res(logic h, logic [PortW-1:0] p, logic [MacW-1:0] m,
                                   logic [DistW-1:0] d, logic [CodeW-1:0] cd);
    outcome_t r;
    r = '{h, p, m, d, cd};
    return r;
  endfunction

  // fill_bias favors inserts so the table runs full
  function automatic cmd_t random_cmd(bit fill_bias);
    cmd_t c;
    int w;
    c.addr    = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(11)] : $urandom;
    c.nh_mac  = MacW'({$urandom, $urandom});
    c.adv_mac = ($urandom_range(3) == 0) ? MacW'({$urandom, $urandom})
                                         : mac_pool[$urandom_range(3)];
    c.own_mac = ($urandom_range(3) == 0) ? MacW'({$urandom, $urandom})
                                         : mac_pool[$urandom_range(3)];
    c.port    = PortW'($urandom);
    c.perm    = 1'($urandom);
    case ($urandom_range(3))
      0: c.metric = DistW'($urandom_range(253, 255));
      1: c.metric = DistW'($urandom_range(0, 3));
      default: c.metric = DistW'($urandom);
    endcase
    w = $urandom_range(99);
    if (fill_bias)
      c.func = (w < 3) ? FUNC_TICK : (w < 25) ? FUNC_LOOKUP : (w < 70) ? FUNC_STATIC :
               (w < 85) ? FUNC_LEARN : FUNC_ADVERT;
    else
      c.func = (w < 12) ? FUNC_TICK : (w < 42) ? FUNC_LOOKUP : (w < 57) ? FUNC_STATIC :
               (w < 72) ? FUNC_LEARN : (w < 97) ? FUNC_ADVERT :
               FuncW'($urandom_range(FuncBadLo, FuncBadHi));
    if (fill_bias && c.func == FUNC_STATIC) c.addr = $urandom;
    return c;
  endfunction

  // start is left high; the next command or an idle gap decides what follows
  task automatic send_cmd(cmd_t c, bit typed, outcome_t want);
    outcome_t r;
    start <= 1'b1;
    in_func <= c.func;
    in_entry_addr <= c.addr;
    in_next_hop_mac <= c.nh_mac;
    in_advertised_mac <= c.adv_mac;
    in_own_port_mac <= c.own_mac;
    in_port <= c.port;
    in_distance <= c.metric;
    in_permanent <= c.perm;
    do @(posedge clk); while (busy);
    r = route_apply(c);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_lifetime(logic [LifeW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    route_lifetime = v;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        results_seen++;
        code_count[out_result_code]++;
        if (out_hit) hits_seen++;
        if (out_hit !== e.hit) begin
          $error("hit: expected %0h, got %0h", e.hit, out_hit); mismatches++;
        end
        if (out_out_port !== e.port) begin
          $error("out_port: expected %0h, got %0h", e.port, out_out_port); mismatches++;
        end
        if (out_out_mac !== e.mac) begin
          $error("out_mac: expected %0h, got %0h", e.mac, out_out_mac); mismatches++;
        end
        if (out_out_distance !== e.metric) begin
          $error("out_distance: expected %0h, got %0h", e.metric, out_out_distance);
          mismatches++;
        end
        if (out_result_code !== e.code) begin
          $error("result_code: expected %0h, got %0h", e.code, out_result_code);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [LifeW-1:0] lifetimes [6];
    outcome_t none;
    none = '0;
    route_lifetime = LifeReset;
    for (int i = 0; i < Depth; i++) begin
      route_valid[i] = 1'b0;
      route_addr[i] = '0; route_mac[i] = '0; route_port[i] = '0;
      route_dist[i] = '0; route_life[i] = '0; route_perm[i] = 1'b0;
    end
    for (int i = 0; i < 12; i++) addr_pool[i] = $urandom;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 0; i < 4; i++) mac_pool[i] = MacW'({$urandom, $urandom});

    directed_rows.push_back('{mk(FUNC_LOOKUP, '0, '0, '0, '0, 0, 0, 0), 1,
                              res(0, 0, '0, 0, CODE_DONE)});
    directed_rows.push_back('{mk(FUNC_TICK, '0, '0, '0, '0, 0, 0, 0), 1,
                              res(0, 0, '0, 0, CODE_DONE)});
    directed_rows.push_back('{mk(FuncBadLo, '1, MacOnes, MacOnes, 0, 7, 255, 1), 1,
                              res(0, 0, '0, 0, CODE_SAME)});
    directed_rows.push_back('{mk(FuncBadHi, '0, '0, '0, '0, 0, 0, 0), 1,
                              res(0, 0, '0, 0, CODE_SAME)});
    directed_rows.push_back('{mk(FUNC_STATIC, '1, MacOnes, '0, '0, 7, 255, 1), 1,
                              res(0, 0, '0, 0, CODE_DONE)});
    directed_rows.push_back('{mk(FUNC_LOOKUP, '1, '0, '0, '0, 0, 0, 0), 1,
                              res(1, 7, MacOnes, 255, CODE_DONE)});
    directed_rows.push_back('{mk(FUNC_STATIC, '0, '0, '0, '0, 0, 0, 0), 1,
                              res(0, 0, '0, 0, CODE_DONE)});
    directed_rows.push_back('{mk(FUNC_LOOKUP, '0, '0, '0, '0, 0, 0, 0), 1,
                              res(1, 0, '0, 0, CODE_DONE)});
    directed_rows.push_back('{mk(FUNC_LEARN, 32'h7fffffff, 48'h0123, '0, '0, 3, 9, 1), 1,
                              res(0, 0, '0, 0, CODE_DONE)});
    directed_rows.push_back('{mk(FUNC_LOOKUP, 32'h7fffffff, '0, '0, '0, 0, 0, 0), 1,
                              res(1, 3, 48'h0123, 1, CODE_DONE)});
    // split horizon: advertised next hop is our own port
    directed_rows.push_back('{mk(FUNC_ADVERT, 32'h7fffffff, 48'h5, 48'h77, 48'h77, 2, 0, 0),
                              1, res(0, 0, '0, 0, CODE_SPLIT)});
    directed_rows.push_back('{mk(FUNC_ADVERT, 32'h7fffffff, 48'h5, 48'h77, 48'h78, 2, 0, 0),
                              0, none});
    directed_rows.push_back('{mk(FUNC_ADVERT, 32'h80000000, 48'h6, MacOnes, '0, 4, 255, 0),
                              0, none});
    directed_rows.push_back('{mk(FUNC_ADVERT, 32'h80000000, 48'h7, '0, MacOnes, 5, 254, 0),
                              0, none});
    directed_rows.push_back('{mk(FUNC_ADVERT, 32'h80000000, 48'h8, 48'h1, 48'h2, 6, 10, 0),
                              0, none});
    directed_rows.push_back('{mk(FUNC_LOOKUP, 32'h80000000, '0, '0, '0, 0, 0, 0), 0, none});
    directed_rows.push_back('{mk(FUNC_LEARN, '0, 48'h9abc, '0, '0, 1, 0, 0), 0, none});
    directed_rows.push_back('{mk(FUNC_LOOKUP, '0, '0, '0, '0, 0, 0, 0), 0, none});
    directed_rows.push_back('{mk(FUNC_TICK, '0, '0, '0, '0, 0, 0, 0), 0, none});
    directed_rows.push_back('{mk(FUNC_LOOKUP, '1, '0, '0, '0, 0, 0, 0), 0, none});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
      maybe_idle();
    end
    drain();

    // first phase keeps the reset lifetime; zero lifetime makes non-permanent routes dead on arrival
    lifetimes = '{LifeReset, 16'd5, 16'hffff, 16'd0, 16'd1, 16'd0};
    lifetimes[5] = LifeW'($urandom_range(2, 60));
    foreach (lifetimes[p]) begin
      if (p != 0) write_lifetime(lifetimes[p]);
      idle_on = (p != 2);
      for (int n = 0; n < PhaseItems; n++) begin
        send_cmd(random_cmd(p == 2), 1'b0, none);
        maybe_idle();
      end
      drain();
    end

    repeat (Latency) @(posedge clk);
    $display("covered %0d commands over 6 lifetime settings, %0d lookup hits",
             results_seen, hits_seen);
    $display("codes done/same/full/split: %0d/%0d/%0d/%0d",
             code_count[0], code_count[1], code_count[2], code_count[3]);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
